// ----- hdl/rpc_pkg.sv -----
// Shared types, codes and constants of the plane consensus core.
`timescale 1ns / 1ps

package rpc_pkg;

    // Default store depth
    localparam int MAX_POINTS_DEF = 1024;

    // Cycles the setup chain needs to settle after the last sample point arrives
    localparam int SETUP_CYCLES = 8;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Result status codes carried in m_tuser
    typedef enum logic [2:0] {
        RES_STORED    = 3'd0,
        RES_FULL      = 3'd1,
        RES_CLEARED   = 3'd2,
        RES_BAD_INDEX = 3'd3,
        RES_DEGEN     = 3'd4,
        RES_EVALUATED = 3'd5
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_INLIER_DISTANCE = 2'd0,
        CFG_MIN_SPACING     = 2'd1,
        CFG_STOP_FRACTION   = 2'd2
    } cfg_index_t;

    // Point store read address source
    typedef enum logic [1:0] {
        RD_SCAN   = 2'd0,
        RD_FIRST  = 2'd1,
        RD_SECOND = 2'd2,
        RD_THIRD  = 2'd3
    } rd_sel_t;

    // Controller sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_SETUP,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_FINISH
    } state_t;

    // Configuration values
    typedef struct packed {
        logic [15:0] inlier_distance;
        logic [15:0] min_spacing;
        logic [8:0]  stop_fraction;
    } cfg_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture_in;
        logic    do_load;
        logic    do_clear;
        rd_sel_t rd_sel;
        logic    cap_p0;
        logic    cap_p1;
        logic    cap_p2;
        logic    scan_clear;
        logic    scan_issue;
        logic    update_best;
        logic    set_status;
        status_t status_code;
        logic    out_load;
    } rpc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic store_full;
        logic idx_ok;
        logic degenerate;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } rpc_stat_t;

endpackage

// ----- hdl/rpc_ctrl.sv -----
// Sequencer of the plane consensus core: steps each transaction through its phases.
`timescale 1ns / 1ps

module rpc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rpc_pkg::rpc_stat_t stat,
    output rpc_pkg::rpc_cmd_t  cmd
);
    import rpc_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] wait_reg, wait_next;

    // State and setup wait counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.op == OP_EVAL && stat.idx_ok)
                    state_next = S_RD0;
                else
                    state_next = S_FINISH;
            end
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_RD2;
            S_RD2:    state_next = S_RD3;
            S_RD3:
            begin
                state_next = S_SETUP;
                wait_next  = 4'(SETUP_CYCLES - 1);
            end
            S_SETUP:
            begin
                if (wait_reg == '0)
                    state_next = S_DECIDE;
                else
                    wait_next = wait_reg - 4'd1;
            end
            S_DECIDE:
            begin
                if (stat.degenerate)
                    state_next = S_FINISH;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_UPDATE;
            end
            S_UPDATE: state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd             = '0;
        cmd.rd_sel      = RD_SCAN;
        cmd.status_code = RES_BAD_INDEX;
        s_tready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.capture_in = s_tvalid;
            end
            S_CHECK:
            begin
                case (stat.op)
                    OP_LOAD:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.do_load     = !stat.store_full;
                        cmd.status_code = stat.store_full ? RES_FULL : RES_STORED;
                    end
                    OP_CLEAR:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.do_clear    = 1'b1;
                        cmd.status_code = RES_CLEARED;
                    end
                    OP_EVAL:
                    begin
                        cmd.set_status  = !stat.idx_ok;
                        cmd.status_code = RES_BAD_INDEX;
                    end
                    default:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = RES_BAD_INDEX;
                    end
                endcase
            end
            S_RD0:    cmd.rd_sel = RD_FIRST;
            S_RD1:
            begin
                cmd.rd_sel = RD_SECOND;
                cmd.cap_p0 = 1'b1;
            end
            S_RD2:
            begin
                cmd.rd_sel = RD_THIRD;
                cmd.cap_p1 = 1'b1;
            end
            S_RD3:    cmd.cap_p2 = 1'b1;
            S_SETUP:  cmd.rd_sel = RD_SCAN;
            S_DECIDE:
            begin
                if (stat.degenerate)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = RES_DEGEN;
                end
                else
                    cmd.scan_clear = 1'b1;
            end
            S_SCAN:   cmd.scan_issue = 1'b1;
            S_DRAIN:  cmd.rd_sel = RD_SCAN;
            S_UPDATE:
            begin
                cmd.update_best = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = RES_EVALUATED;
            end
            S_FINISH: cmd.out_load = stat.out_free;
            default:  cmd.rd_sel = RD_SCAN;
        endcase
    end

endmodule

// ----- hdl/rpc_datapath.sv -----
// Datapath of the plane consensus core: point store, plane setup, scan pipeline, result.
`timescale 1ns / 1ps

module rpc_datapath
#(
    parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rpc_pkg::cfg_t      cfg,
    input  rpc_pkg::rpc_cmd_t  cmd,
    output rpc_pkg::rpc_stat_t stat,
    input  logic [1:0]         s_tuser,
    input  logic [79:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [2:0]         m_tuser,
    output logic [183:0]       m_tdata
);
    import rpc_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int IW   = (AW > 10) ? AW : 10;
    localparam int CMPW = (CW > 10) ? CW : 10;

    // Latched input transaction
    op_t               op_reg;
    logic signed [15:0] in_x_reg, in_y_reg, in_z_reg;
    logic [9:0]        smp0_reg, smp1_reg, smp2_reg;

    // Store control
    logic [CW-1:0] count_reg;
    logic [47:0]   mem [MAX_POINTS];
    logic [47:0]   rdata_reg;
    logic [AW-1:0] rd_addr;
    logic [IW-1:0] smp0_w, smp1_w, smp2_w;

    // Sample points
    logic signed [15:0] p0x_reg, p0y_reg, p0z_reg;
    logic signed [15:0] p1x_reg, p1y_reg, p1z_reg;
    logic signed [15:0] p2x_reg, p2y_reg, p2z_reg;

    // Setup chain
    logic signed [16:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [16:0] cx_reg, cy_reg, cz_reg;
    logic signed [33:0] cr0_reg, cr1_reg, cr2_reg, cr3_reg, cr4_reg, cr5_reg;
    logic signed [33:0] sqa [3];
    logic signed [33:0] sqb [3];
    logic signed [33:0] sqc [3];
    logic [32:0]        sqa_reg [3];
    logic [32:0]        sqb_reg [3];
    logic [32:0]        sqc_reg [3];
    logic [31:0]        lim_reg, t2_reg;
    logic signed [34:0] nx_reg, ny_reg, nz_reg;
    logic [34:0]        d2a_reg, d2b_reg, d2c_reg;
    logic [34:0]        nxa, nya, nza;
    logic               degen_reg;
    logic signed [50:0] ox_reg, oy_reg, oz_reg;
    logic [67:0]        nnx_reg, nny_reg, nnz_reg;
    logic signed [52:0] d_reg;
    logic [69:0]        nn_reg;
    logic [66:0]        rlo_reg, rhi_reg;
    logic [103:0]       rhs_reg;

    // Scan pipeline
    logic [CW-1:0]      scan_idx_reg, scan_cnt_reg;
    logic               vr_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [50:0] px_reg, py_reg, pz_reg;
    logic signed [52:0] e_sum;
    logic signed [52:0] e_abs;
    logic [51:0]        m_reg;
    logic [51:0]        hh_reg, hl_reg, ll_reg;
    logic [103:0]       lhs_reg;

    // Result and best plane
    status_t            status_reg;
    logic [CW-1:0]      total_reg, best_reg;
    logic               improved_reg;
    logic signed [34:0] bnx_reg, bny_reg, bnz_reg;
    logic signed [52:0] boff_reg;
    logic [CW+8:0]      stop_lhs, stop_rhs;
    logic               stop;

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            op_reg   <= op_t'(s_tuser);
            in_x_reg <= s_tdata[15:0];
            in_y_reg <= s_tdata[31:16];
            in_z_reg <= s_tdata[47:32];
            smp0_reg <= s_tdata[57:48];
            smp1_reg <= s_tdata[67:58];
            smp2_reg <= s_tdata[77:68];
        end
    end

    // Index widening and read address select
    assign smp0_w = IW'(smp0_reg);
    assign smp1_w = IW'(smp1_reg);
    assign smp2_w = IW'(smp2_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST:  rd_addr = smp0_w[AW-1:0];
            RD_SECOND: rd_addr = smp1_w[AW-1:0];
            RD_THIRD:  rd_addr = smp2_w[AW-1:0];
            default:   rd_addr = scan_idx_reg[AW-1:0];
        endcase
    end

    // Point store
    always_ff @(posedge clk)
    begin
        if (cmd.do_load)
            mem[count_reg[AW-1:0]] <= {in_z_reg, in_y_reg, in_x_reg};
        rdata_reg <= mem[rd_addr];
    end

    // Point count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.do_clear)
            count_reg <= '0;
        else if (cmd.do_load)
            count_reg <= count_reg + CW'(1);
    end

    // Sample point capture
    always_ff @(posedge clk)
    begin
        if (cmd.cap_p0)
        begin
            p0x_reg <= rdata_reg[15:0];
            p0y_reg <= rdata_reg[31:16];
            p0z_reg <= rdata_reg[47:32];
        end
        if (cmd.cap_p1)
        begin
            p1x_reg <= rdata_reg[15:0];
            p1y_reg <= rdata_reg[31:16];
            p1z_reg <= rdata_reg[47:32];
        end
        if (cmd.cap_p2)
        begin
            p2x_reg <= rdata_reg[15:0];
            p2y_reg <= rdata_reg[31:16];
            p2z_reg <= rdata_reg[47:32];
        end
    end

    // Squares of the pair differences
    always_comb
    begin
        sqa[0] = ax_reg * ax_reg;
        sqa[1] = ay_reg * ay_reg;
        sqa[2] = az_reg * az_reg;
        sqb[0] = bx_reg * bx_reg;
        sqb[1] = by_reg * by_reg;
        sqb[2] = bz_reg * bz_reg;
        sqc[0] = cx_reg * cx_reg;
        sqc[1] = cy_reg * cy_reg;
        sqc[2] = cz_reg * cz_reg;
    end

    // Normal magnitudes
    assign nxa = nx_reg[34] ? 35'(-nx_reg) : 35'(nx_reg);
    assign nya = ny_reg[34] ? 35'(-ny_reg) : 35'(ny_reg);
    assign nza = nz_reg[34] ? 35'(-nz_reg) : 35'(nz_reg);

    // Setup chain: differences, cross products, normal, offset, threshold
    always_ff @(posedge clk)
    begin
        ax_reg <= 17'(p0x_reg) - 17'(p1x_reg);
        ay_reg <= 17'(p0y_reg) - 17'(p1y_reg);
        az_reg <= 17'(p0z_reg) - 17'(p1z_reg);
        bx_reg <= 17'(p1x_reg) - 17'(p2x_reg);
        by_reg <= 17'(p1y_reg) - 17'(p2y_reg);
        bz_reg <= 17'(p1z_reg) - 17'(p2z_reg);
        cx_reg <= 17'(p0x_reg) - 17'(p2x_reg);
        cy_reg <= 17'(p0y_reg) - 17'(p2y_reg);
        cz_reg <= 17'(p0z_reg) - 17'(p2z_reg);

        cr0_reg <= 34'(ay_reg) * 34'(bz_reg);
        cr1_reg <= 34'(az_reg) * 34'(by_reg);
        cr2_reg <= 34'(az_reg) * 34'(bx_reg);
        cr3_reg <= 34'(ax_reg) * 34'(bz_reg);
        cr4_reg <= 34'(ax_reg) * 34'(by_reg);
        cr5_reg <= 34'(ay_reg) * 34'(bx_reg);
        for (int k = 0; k < 3; k++)
        begin
            sqa_reg[k] <= sqa[k][32:0];
            sqb_reg[k] <= sqb[k][32:0];
            sqc_reg[k] <= sqc[k][32:0];
        end
        lim_reg <= 32'(cfg.min_spacing) * 32'(cfg.min_spacing);
        t2_reg  <= 32'(cfg.inlier_distance) * 32'(cfg.inlier_distance);

        nx_reg  <= 35'(cr0_reg) - 35'(cr1_reg);
        ny_reg  <= 35'(cr2_reg) - 35'(cr3_reg);
        nz_reg  <= 35'(cr4_reg) - 35'(cr5_reg);
        d2a_reg <= 35'(sqa_reg[0]) + 35'(sqa_reg[1]) + 35'(sqa_reg[2]);
        d2b_reg <= 35'(sqb_reg[0]) + 35'(sqb_reg[1]) + 35'(sqb_reg[2]);
        d2c_reg <= 35'(sqc_reg[0]) + 35'(sqc_reg[1]) + 35'(sqc_reg[2]);

        // Zero normal or a pair of sample points too close together
        degen_reg <= (nx_reg == '0 && ny_reg == '0 && nz_reg == '0)
                     || (d2a_reg < 35'(lim_reg))
                     || (d2b_reg < 35'(lim_reg))
                     || (d2c_reg < 35'(lim_reg));
        ox_reg  <= 51'(nx_reg) * 51'(p0x_reg);
        oy_reg  <= 51'(ny_reg) * 51'(p0y_reg);
        oz_reg  <= 51'(nz_reg) * 51'(p0z_reg);
        nnx_reg <= 68'(nxa[33:0]) * 68'(nxa[33:0]);
        nny_reg <= 68'(nya[33:0]) * 68'(nya[33:0]);
        nnz_reg <= 68'(nza[33:0]) * 68'(nza[33:0]);

        d_reg  <= -(53'(ox_reg) + 53'(oy_reg) + 53'(oz_reg));
        nn_reg <= 70'(nnx_reg) + 70'(nny_reg) + 70'(nnz_reg);

        // Threshold n.n * t^2 in two partial products
        rlo_reg <= 67'(nn_reg[34:0]) * 67'(t2_reg);
        rhi_reg <= 67'(nn_reg[69:35]) * 67'(t2_reg);
        rhs_reg <= (104'(rhi_reg) << 35) + 104'(rlo_reg);
    end

    // Scan index and inlier count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            scan_cnt_reg <= '0;
            vr_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else
        begin
            vr_reg <= cmd.scan_issue;
            v1_reg <= vr_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.scan_clear)
            begin
                scan_idx_reg <= '0;
                scan_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.scan_issue)
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                if (v4_reg && lhs_reg <= rhs_reg)
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
            end
        end
    end

    // Residual of the plane equation and its magnitude
    assign e_sum = 53'(px_reg) + 53'(py_reg) + 53'(pz_reg) + d_reg;
    assign e_abs = e_sum[52] ? -e_sum : e_sum;

    // Scan pipeline: products, residual, square partials, square
    always_ff @(posedge clk)
    begin
        px_reg  <= 51'(nx_reg) * 51'($signed(rdata_reg[15:0]));
        py_reg  <= 51'(ny_reg) * 51'($signed(rdata_reg[31:16]));
        pz_reg  <= 51'(nz_reg) * 51'($signed(rdata_reg[47:32]));
        m_reg   <= e_abs[51:0];
        hh_reg  <= 52'(m_reg[51:26]) * 52'(m_reg[51:26]);
        hl_reg  <= 52'(m_reg[51:26]) * 52'(m_reg[25:0]);
        ll_reg  <= 52'(m_reg[25:0]) * 52'(m_reg[25:0]);
        lhs_reg <= (104'(hh_reg) << 52) + (104'(hl_reg) << 27) + 104'(ll_reg);
    end

    // Per-transaction result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            total_reg    <= '0;
            improved_reg <= 1'b0;
        end
        else if (cmd.update_best)
        begin
            total_reg    <= scan_cnt_reg;
            improved_reg <= (scan_cnt_reg > best_reg);
        end
        if (cmd.set_status)
            status_reg <= cmd.status_code;
    end

    // Best plane so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
            bnx_reg  <= '0;
            bny_reg  <= '0;
            bnz_reg  <= '0;
            boff_reg <= '0;
        end
        else if (cmd.do_clear)
        begin
            best_reg <= '0;
            bnx_reg  <= '0;
            bny_reg  <= '0;
            bnz_reg  <= '0;
            boff_reg <= '0;
        end
        else if (cmd.update_best && scan_cnt_reg > best_reg)
        begin
            best_reg <= scan_cnt_reg;
            bnx_reg  <= nx_reg;
            bny_reg  <= ny_reg;
            bnz_reg  <= nz_reg;
            boff_reg <= d_reg;
        end
    end

    // Stop test on an evaluated result: best * 256 >= stop_fraction * count
    assign stop_lhs = (CW+9)'(best_reg) << 8;
    assign stop_rhs = (CW+9)'(cfg.stop_fraction) * (CW+9)'(count_reg);
    assign stop     = (status_reg == RES_EVALUATED) && (stop_lhs >= stop_rhs);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (cmd.out_load)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tuser <= status_reg;
            m_tdata <= {7'd0, boff_reg[50:0], bnz_reg[33:0], bny_reg[33:0],
                        bnx_reg[33:0], stop, improved_reg,
                        11'(best_reg), 11'(total_reg)};
        end
    end

    // Status to controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.store_full = (count_reg == CW'(MAX_POINTS));
        stat.idx_ok     = (CMPW'(smp0_reg) < CMPW'(count_reg))
                          && (CMPW'(smp1_reg) < CMPW'(count_reg))
                          && (CMPW'(smp2_reg) < CMPW'(count_reg));
        stat.degenerate = degen_reg;
        stat.scan_last  = ((scan_idx_reg + CW'(1)) == count_reg);
        stat.pipe_busy  = vr_reg | v1_reg | v2_reg | v3_reg | v4_reg;
        stat.out_free   = !m_tvalid || m_tready;
    end

endmodule

// ----- hdl/ransac_plane_consensus_core.sv -----
// Top level of the plane consensus core: configuration registers, sequencer and datapath.
`timescale 1ns / 1ps

// Points are loaded into a store of MAX_POINTS entries; an evaluate transaction names three
// stored points, forms the plane through them and counts the stored points within
// inlier_distance of it, keeping the best plane seen. One transaction is handled at a time.
// In a non-degenerate evaluation the single read port of the point store walks every
// stored point once, one per cycle, after a setup that fetches the three sample points
// and forms normal, offset and threshold, and before a pipeline drain. A degenerate
// hypothesis answers after the setup. A finished result waits in the output register
// while the next transaction is taken in.
module ransac_plane_consensus_core
#(
    parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // operation
    input  logic [79:0]  s_tdata,   // coord_x, coord_y, coord_z, sample_first,
                                    // sample_second, sample_third, zero pad
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // status
    output logic [183:0] m_tdata    // inlier_total, best_total, improved, stop_reached,
                                    // normal_x, normal_y, normal_z, plane_offset, zero pad
);
    import rpc_pkg::*;

    cfg_t      cfg_reg;
    rpc_cmd_t  cmd;
    rpc_stat_t stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inlier_distance <= 16'd16;
            cfg_reg.min_spacing     <= 16'd1;
            cfg_reg.stop_fraction   <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_INLIER_DISTANCE: cfg_reg.inlier_distance <= cfg_data;
                CFG_MIN_SPACING:     cfg_reg.min_spacing     <= cfg_data;
                CFG_STOP_FRACTION:   cfg_reg.stop_fraction   <= cfg_data[8:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Sequencer
    rpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    rpc_datapath
    #(
        .MAX_POINTS (MAX_POINTS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- verif/tb_ransac_plane_consensus_core.sv -----
// Self-checking testbench for the plane consensus core with a built-in plane scoring predictor.
`timescale 1ns / 1ps

module tb_ransac_plane_consensus_core;
    import rpc_pkg::*;

    localparam int DEPTH = MAX_POINTS_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 60;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] x, y, z;
        logic [9:0]         s0, s1, s2;
    } txn_in_t;

    typedef struct {
        status_t            status;
        logic [10:0]        inliers;
        logic [10:0]        best;
        logic               improved;
        logic               stop;
        logic [33:0]        nx, ny, nz;
        logic [50:0]        offset;
    } plane_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = CFG_INLIER_DISTANCE;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = OP_LOAD;
    logic [79:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [2:0]   m_tuser;
    logic [183:0] m_tdata;

    // Predictor state
    logic signed [15:0] pt_x [DEPTH];
    logic signed [15:0] pt_y [DEPTH];
    logic signed [15:0] pt_z [DEPTH];
    int     num_points = 0;
    int     best_count = 0;
    longint best_nx = 0, best_ny = 0, best_nz = 0, best_d = 0;
    longint inlier_dist = 16, min_space = 1, stop_frac = 256;

    plane_result_t pending_results[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycles = 0;

    ransac_plane_consensus_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic pair_close(int i, int j);
        longint dx, dy, dz;
        dx = longint'(pt_x[i]) - pt_x[j];
        dy = longint'(pt_y[i]) - pt_y[j];
        dz = longint'(pt_z[i]) - pt_z[j];
        return (dx * dx + dy * dy + dz * dz) < min_space * min_space;
    endfunction

    // Plane scoring predictor: updates the point store and best plane, returns the result
    function automatic plane_result_t score_txn(txn_in_t t);
        plane_result_t r;
        longint x0, y0, z0, ax, ay, az, bx, by, bz, nx, ny, nz, d, e;
        wide_t nn, thr, err2;
        int hits;
        r.status = RES_BAD_INDEX;
        r.inliers = '0;
        r.improved = 1'b0;
        r.stop = 1'b0;
        if (t.op == OP_LOAD)
        begin
            if (num_points >= DEPTH)
                r.status = RES_FULL;
            else
            begin
                pt_x[num_points] = t.x;
                pt_y[num_points] = t.y;
                pt_z[num_points] = t.z;
                num_points++;
                r.status = RES_STORED;
            end
        end
        else if (t.op == OP_CLEAR)
        begin
            num_points = 0;
            best_count = 0;
            best_nx = 0; best_ny = 0; best_nz = 0; best_d = 0;
            r.status = RES_CLEARED;
        end
        else if (t.op == OP_EVAL && t.s0 < num_points && t.s1 < num_points
                 && t.s2 < num_points)
        begin
            x0 = pt_x[t.s0]; y0 = pt_y[t.s0]; z0 = pt_z[t.s0];
            ax = x0 - pt_x[t.s1]; ay = y0 - pt_y[t.s1]; az = z0 - pt_z[t.s1];
            bx = longint'(pt_x[t.s1]) - pt_x[t.s2];
            by = longint'(pt_y[t.s1]) - pt_y[t.s2];
            bz = longint'(pt_z[t.s1]) - pt_z[t.s2];
            nx = ay * bz - az * by;
            ny = az * bx - ax * bz;
            nz = ax * by - ay * bx;
            if ((nx == 0 && ny == 0 && nz == 0) || pair_close(t.s0, t.s1)
                || pair_close(t.s0, t.s2) || pair_close(t.s1, t.s2))
                r.status = RES_DEGEN;
            else
            begin
                d = -(nx * x0 + ny * y0 + nz * z0);
                nn = wide_t'(nx) * wide_t'(nx) + wide_t'(ny) * wide_t'(ny)
                     + wide_t'(nz) * wide_t'(nz);
                thr = nn * (wide_t'(inlier_dist) * wide_t'(inlier_dist));
                hits = 0;
                for (int i = 0; i < num_points; i++)
                begin
                    e = nx * pt_x[i] + ny * pt_y[i] + nz * pt_z[i] + d;
                    err2 = wide_t'(e) * wide_t'(e);
                    if (err2 <= thr)
                        hits++;
                end
                r.inliers = 11'(hits);
                if (hits > best_count)
                begin
                    best_count = hits;
                    best_nx = nx; best_ny = ny; best_nz = nz; best_d = d;
                    r.improved = 1'b1;
                end
                r.stop = (longint'(best_count) * 256 >= stop_frac * num_points);
                r.status = RES_EVALUATED;
            end
        end
        r.best = 11'(best_count);
        r.nx = best_nx[33:0];
        r.ny = best_ny[33:0];
        r.nz = best_nz[33:0];
        r.offset = best_d[50:0];
        return r;
    endfunction

    function automatic void check_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $realtime, nm, exp_v, act_v);
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        plane_result_t r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %h %h",
                         $realtime, m_tuser, m_tdata);
            end
            else
            begin
                r = pending_results.pop_front();
                check_field("status", r.status, m_tuser);
                check_field("inlier_total", r.inliers, m_tdata[10:0]);
                check_field("best_total", r.best, m_tdata[21:11]);
                check_field("improved", r.improved, m_tdata[22]);
                check_field("stop_reached", r.stop, m_tdata[23]);
                check_field("normal_x", r.nx, m_tdata[57:24]);
                check_field("normal_y", r.ny, m_tdata[91:58]);
                check_field("normal_z", r.nz, m_tdata[125:92]);
                check_field("plane_offset", r.offset, m_tdata[176:126]);
            end
        end
    end

    // Send one transaction, with random idle cycles ahead of it
    task automatic send_txn(logic [1:0] op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [9:0] s0, logic [9:0] s1, logic [9:0] s2);
        txn_in_t t;
        t.op = op; t.x = x; t.y = y; t.z = z; t.s0 = s0; t.s1 = s1; t.s2 = s2;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, s2, s1, s0, z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results = {pending_results, score_txn(t)};
    endtask

    task automatic load_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send_txn(OP_LOAD, x, y, z, $urandom, $urandom, $urandom);
    endtask

    task automatic eval_hyp(logic [9:0] s0, logic [9:0] s1, logic [9:0] s2);
        send_txn(OP_EVAL, $urandom, $urandom, $urandom, s0, s1, s2);
    endtask

    task automatic clear_store();
        send_txn(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write, only with the core idle
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INLIER_DISTANCE: inlier_dist = val;
            CFG_MIN_SPACING:     min_space = val;
            CFG_STOP_FRACTION:   stop_frac = val[8:0];
            default: ;
        endcase
    endtask

    // Point near the plane z = a*x + b*y + c, or a full-range outlier
    task automatic load_plane_point(int a, int b, int c, logic outlier);
        int x, y;
        if (outlier)
            load_point(16'($urandom), 16'($urandom), 16'($urandom));
        else
        begin
            x = $signed($urandom_range(4000)) - 2000;
            y = $signed($urandom_range(4000)) - 2000;
            load_point(16'(x), 16'(y), 16'(a * x + b * y + c + $signed($urandom_range(6)) - 3));
        end
    endtask

    task automatic test_directed();
        eval_hyp(0, 0, 0);
        send_txn(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff, 10'h3ff);
        load_point(16'h8000, 16'h8000, 16'h8000);
        load_point(16'h0000, 16'h0000, 16'h0000);
        load_point(16'h7fff, 16'h7fff, 16'h7fff);
        load_point(16'h7fff, 16'h8000, 16'h0000);
        load_point(16'h8000, 16'h7fff, 16'h1234);
        // collinear samples: zero normal
        eval_hyp(0, 1, 2);
        // repeated index
        eval_hyp(3, 3, 4);
        eval_hyp(0, 3, 4);
        eval_hyp(2, 3, 4);
        eval_hyp(1, 3, 4);
        eval_hyp(5, 1, 2);
        eval_hyp(0, 1, 10'h3ff);
        send_txn(OP_UNUSED, 0, 0, 0, 0, 1, 3);
        clear_store();
        eval_hyp(0, 1, 3);
        load_point(10, 0, 0);
        load_point(0, 10, 0);
        load_point(0, 0, 10);
        load_point(5, 5, 0);
        eval_hyp(0, 1, 2);
        eval_hyp(0, 1, 3);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MIN_SPACING, 16'd0);
        eval_hyp(1, 1, 2);
        eval_hyp(0, 1, 3);
        write_reg(CFG_MIN_SPACING, 16'hffff);
        eval_hyp(0, 1, 2);
        write_reg(CFG_MIN_SPACING, 16'd1);
        write_reg(CFG_INLIER_DISTANCE, 16'd0);
        eval_hyp(2, 1, 0);
        write_reg(CFG_INLIER_DISTANCE, 16'hffff);
        write_reg(CFG_STOP_FRACTION, 9'd0);
        eval_hyp(0, 2, 3);
        write_reg(CFG_STOP_FRACTION, 9'h1ff);
        eval_hyp(3, 2, 0);
        write_reg(CFG_STOP_FRACTION, 9'd256);
        eval_hyp(1, 0, 3);
        write_reg(CFG_INLIER_DISTANCE, 16'd16);
    endtask

    task automatic test_full_store();
        clear_store();
        for (int i = 0; i < DEPTH; i++)
            load_plane_point(1, -2, 37, $urandom_range(9) == 0);
        load_point(16'h7fff, 16'h8000, 16'h7fff);
        eval_hyp(10'h3ff, 0, 10'h200);
        eval_hyp(5, 10'h2aa, 10'h155);
        write_reg(CFG_STOP_FRACTION, 9'd128);
        eval_hyp(10'h3fe, 1, 10'h1ff);
    endtask

    task automatic test_random(int n_items);
        int sent, n_pts, a, b, c;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_INLIER_DISTANCE, $urandom_range(3) == 0 ? $urandom
                                               : $urandom_range(64));
                write_reg(CFG_MIN_SPACING, $urandom_range(7) == 0 ? $urandom
                                           : $urandom_range(200));
                write_reg(CFG_STOP_FRACTION, $urandom_range(300));
            end
            clear_store();
            n_pts = $urandom_range(4, 40);
            a = $signed($urandom_range(6)) - 3;
            b = $signed($urandom_range(6)) - 3;
            c = $signed($urandom_range(2000)) - 1000;
            for (int i = 0; i < n_pts; i++)
                load_plane_point(a, b, c, $urandom_range(3) == 0);
            repeat ($urandom_range(3, 10))
            begin
                case ($urandom_range(9))
                    0: eval_hyp($urandom, $urandom, $urandom);
                    1: send_txn(OP_UNUSED, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
                    2: eval_hyp($urandom_range(n_pts - 1), $urandom_range(n_pts - 1),
                                $urandom_range(n_pts, 1023));
                    default: eval_hyp($urandom_range(n_pts - 1), $urandom_range(n_pts - 1),
                                      $urandom_range(n_pts - 1));
                endcase
                sent++;
            end
            sent += n_pts + 1;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_full_store();
        drain();
        send_idle_pct = 82;
        test_random(140);
        // hold off until all results are back
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 82;
        test_random(140);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random(140);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(150);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rpc_pkg.sv
hdl/rpc_ctrl.sv
hdl/rpc_datapath.sv
hdl/ransac_plane_consensus_core.sv
verif/tb_ransac_plane_consensus_core.sv
